@@ rtl/obsr_pkg.sv @@
// Package for the one-bit speaker PCM resampler: payload types, state enums,
// register indexes, width constants and the saturating accumulator add.
// Used by every RTL file of the block; depends on nothing.
package obsr_pkg;

    localparam int CYC_W     = 8;
    localparam int RATE_W    = 18;
    localparam int CLK_W     = 32;
    localparam int AMP_W     = 15;
    localparam int ACC_W     = 33;
    localparam int SAMPLE_W  = 16;
    localparam int PROD_W    = RATE_W + CYC_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CYC_W-1:0] MAX_TICK_CYCLES = CYC_W'(255);
    localparam int MAX_RESULTS = 64;
    localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

    // One quotient bit per step; the quotient never exceeds the amplitude.
    localparam int DIV_STEPS  = AMP_W;
    localparam int DIV_STEP_W = $clog2(DIV_STEPS);

    localparam logic                RST_CAPTURE   = 1'b1;
    localparam logic [CLK_W-1:0]    RST_CPU_CLOCK = CLK_W'(3500000);
    localparam logic [RATE_W-1:0]   RST_OUT_RATE  = RATE_W'(48000);
    localparam logic [AMP_W-1:0]    RST_AMPLITUDE = AMP_W'(8192);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPTURE_ENABLE = 2'd0,
        CFG_CPU_CLOCK_HZ   = 2'd1,
        CFG_OUTPUT_RATE_HZ = 2'd2,
        CFG_AMPLITUDE      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CYC_W-1:0] cycles;
        logic             speaker_level;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } t_out_item;

    typedef struct packed {
        logic [ACC_W-1:0] mag;
        logic             neg;
        logic [ACC_W-1:0] divisor;
        logic [AMP_W-1:0] amp;
    } t_div_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_CHECK,
        ST_SEL,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_MUL,
        DV_STEP,
        DV_DONE
    } t_div_state;

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
    endfunction

endpackage

@@ rtl/one_bit_speaker_pcm_resampler.sv @@
// Top level of the one-bit speaker PCM resampler: configuration registers,
// accumulators, phase sequencer and output register. Depends on obsr_pkg, obsr_div.
//
// Channel   Direction  Handshake              Payload
// in        to block   i_in_valid/o_in_stall  i_in_data  (cycles, speaker_level)
// out       from block o_out_valid/i_out_stall o_out_data (sample, last_sample)
// cfg       to block   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// An active tick that produces no sample passes through ST_ADD and ST_CHECK. Each
// sample passes through ST_CHECK, ST_SEL and ST_EMIT, waiting in ST_EMIT while the
// output stalls; the first sample of a tick with a non-empty window also runs the
// multiply and the 15-step restoring divider in ST_DIV.
// Synchronous active-low reset restores the register defaults and clears the
// accumulators. A stalled result holds o_out_data; inputs stay stalled meanwhile.
module one_bit_speaker_pcm_resampler (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  obsr_pkg::t_in_item                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output obsr_pkg::t_out_item                  o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [obsr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [obsr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int ACC_W = obsr_pkg::ACC_W;

    obsr_pkg::t_state r_state, n_state;

    logic                             r_capture;
    logic [obsr_pkg::CLK_W-1:0]       r_cpu_clock;
    logic [obsr_pkg::RATE_W-1:0]      r_out_rate;
    logic [obsr_pkg::AMP_W-1:0]       r_amplitude;

    logic [obsr_pkg::CYC_W-1:0]       r_cyc, n_cyc;
    logic                             r_high, n_high;
    logic [obsr_pkg::PROD_W-1:0]      r_prod, n_prod;
    logic [ACC_W-1:0]                 r_sum, n_sum;
    logic [ACC_W-1:0]                 r_win, n_win;
    logic [ACC_W-1:0]                 r_phase, n_phase;
    logic [obsr_pkg::COUNT_W-1:0]     r_count, n_count;
    logic                             r_last, n_last;
    logic signed [obsr_pkg::SAMPLE_W-1:0] r_sample, n_sample;

    logic                             w_in_xfer;
    logic                             w_active;
    logic                             w_hit;
    logic                             w_room;
    logic [ACC_W+1:0]                 w_pos;
    logic [ACC_W+1:0]                 w_negd;
    logic                             w_div_start;
    logic                             w_div_done;
    logic signed [obsr_pkg::SAMPLE_W-1:0] w_div_quot;
    obsr_pkg::t_div_req               w_req;

    assign w_in_xfer = i_in_valid && !o_in_stall;
    assign w_active  = r_capture && (i_in_data.cycles != '0);
    assign w_hit     = (r_phase >= {1'b0, r_cpu_clock});
    assign w_room    = (r_count != obsr_pkg::COUNT_W'(obsr_pkg::MAX_RESULTS));

    // Centred value 2*sum - window as sign and magnitude.
    assign w_pos  = {1'b0, r_sum, 1'b0} - {2'b00, r_win};
    assign w_negd = {2'b00, r_win} - {1'b0, r_sum, 1'b0};

    always_comb begin
        w_req.neg     = w_pos[ACC_W+1];
        w_req.mag     = w_pos[ACC_W+1] ? w_negd[ACC_W-1:0] : w_pos[ACC_W-1:0];
        w_req.divisor = r_win;
        w_req.amp     = r_amplitude;
    end

    obsr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_req   (w_req),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            obsr_pkg::ST_IDLE: begin
                if (w_in_xfer && w_active) begin
                    n_state = obsr_pkg::ST_ADD;
                end
            end
            obsr_pkg::ST_ADD:   n_state = obsr_pkg::ST_CHECK;
            obsr_pkg::ST_CHECK: begin
                n_state = (w_hit && w_room) ? obsr_pkg::ST_SEL : obsr_pkg::ST_IDLE;
            end
            obsr_pkg::ST_SEL: begin
                n_state = (r_win != '0) ? obsr_pkg::ST_DIV : obsr_pkg::ST_EMIT;
            end
            obsr_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = obsr_pkg::ST_EMIT;
                end
            end
            obsr_pkg::ST_EMIT: begin
                if (!i_out_stall) begin
                    n_state = obsr_pkg::ST_CHECK;
                end
            end
            default: n_state = obsr_pkg::ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_stall  = (r_state != obsr_pkg::ST_IDLE);
        o_out_valid = (r_state == obsr_pkg::ST_EMIT);
        o_cfg_ready = 1'b1;
        w_div_start = (r_state == obsr_pkg::ST_SEL) && (r_win != '0);
        o_out_data.sample      = r_sample;
        o_out_data.last_sample = r_last;
    end

    // Datapath.
    always_comb begin
        n_cyc    = r_cyc;
        n_high   = r_high;
        n_prod   = r_prod;
        n_sum    = r_sum;
        n_win    = r_win;
        n_phase  = r_phase;
        n_count  = r_count;
        n_last   = r_last;
        n_sample = r_sample;
        case (r_state)
            obsr_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    n_cyc  = (i_in_data.cycles > obsr_pkg::MAX_TICK_CYCLES) ?
                             obsr_pkg::MAX_TICK_CYCLES : i_in_data.cycles;
                    n_high = i_in_data.speaker_level;
                    n_prod = obsr_pkg::PROD_W'(r_out_rate) *
                             obsr_pkg::PROD_W'(n_cyc);
                end
            end
            obsr_pkg::ST_ADD: begin
                if (r_high) begin
                    n_sum = obsr_pkg::sat_add(r_sum, ACC_W'(r_cyc));
                end
                n_win   = obsr_pkg::sat_add(r_win, ACC_W'(r_cyc));
                n_phase = obsr_pkg::sat_add(r_phase, ACC_W'(r_prod));
                n_count = '0;
            end
            obsr_pkg::ST_CHECK: begin
                if (w_hit && w_room) begin
                    n_phase = r_phase - {1'b0, r_cpu_clock};
                    n_count = r_count + 1'b1;
                end else if (w_hit) begin
                    // Sample limit reached with the phase still due: drop the excess.
                    n_phase = '0;
                end
            end
            obsr_pkg::ST_SEL: begin
                n_last   = !w_room || !w_hit;
                n_sample = '0;
                // The divider has taken its operands; later samples see an empty window.
                n_sum    = '0;
                n_win    = '0;
            end
            obsr_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_sample = w_div_quot;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= obsr_pkg::ST_IDLE;
            r_sum   <= '0;
            r_win   <= '0;
            r_phase <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_win   <= n_win;
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cyc    <= n_cyc;
        r_high   <= n_high;
        r_prod   <= n_prod;
        r_last   <= n_last;
        r_sample <= n_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capture   <= obsr_pkg::RST_CAPTURE;
            r_cpu_clock <= obsr_pkg::RST_CPU_CLOCK;
            r_out_rate  <= obsr_pkg::RST_OUT_RATE;
            r_amplitude <= obsr_pkg::RST_AMPLITUDE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (obsr_pkg::t_cfg_idx'(i_cfg_index))
                obsr_pkg::CFG_CAPTURE_ENABLE: r_capture   <= i_cfg_data[0];
                obsr_pkg::CFG_CPU_CLOCK_HZ:   r_cpu_clock <= i_cfg_data[obsr_pkg::CLK_W-1:0];
                obsr_pkg::CFG_OUTPUT_RATE_HZ: r_out_rate  <= i_cfg_data[obsr_pkg::RATE_W-1:0];
                obsr_pkg::CFG_AMPLITUDE:      r_amplitude <= i_cfg_data[obsr_pkg::AMP_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

@@ rtl/obsr_div.sv @@
// Sequential signed scaler for the resampler: |centred| * amplitude / window,
// a multiply in DV_MUL, then one restoring-division step per quotient bit.
// Depends on obsr_pkg.
module obsr_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  obsr_pkg::t_div_req                  i_req,
    output logic                                o_done,
    output logic signed [obsr_pkg::SAMPLE_W-1:0] o_quot
);

    obsr_pkg::t_div_state r_state, n_state;

    logic [obsr_pkg::DIV_STEP_W-1:0] r_step, n_step;
    logic [obsr_pkg::ACC_W-1:0]      r_rem, n_rem;
    logic [obsr_pkg::AMP_W-1:0]      r_quo, n_quo;
    logic [obsr_pkg::ACC_W-1:0]      r_mag, n_mag;
    logic [obsr_pkg::ACC_W-1:0]      r_div, n_div;
    logic [obsr_pkg::AMP_W-1:0]      r_amp, n_amp;
    logic                            r_neg, n_neg;

    localparam int PRODW = obsr_pkg::ACC_W + obsr_pkg::AMP_W;

    logic [PRODW-1:0]             w_prod;
    logic [obsr_pkg::ACC_W:0]     w_trial;
    logic                         w_fit;
    logic [obsr_pkg::SAMPLE_W-1:0] w_q_ext;

    assign w_prod  = PRODW'(r_mag) * PRODW'(r_amp);
    assign w_trial = {r_rem, r_quo[obsr_pkg::AMP_W-1]} - {1'b0, r_div};
    assign w_fit   = !w_trial[obsr_pkg::ACC_W];
    assign w_q_ext = {1'b0, r_quo};

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            obsr_pkg::DV_IDLE: begin
                if (i_start) begin
                    n_state = obsr_pkg::DV_MUL;
                end
            end
            obsr_pkg::DV_MUL:  n_state = obsr_pkg::DV_STEP;
            obsr_pkg::DV_STEP: begin
                if (r_step == obsr_pkg::DIV_STEP_W'(obsr_pkg::DIV_STEPS - 1)) begin
                    n_state = obsr_pkg::DV_DONE;
                end
            end
            obsr_pkg::DV_DONE: n_state = obsr_pkg::DV_IDLE;
            default:           n_state = obsr_pkg::DV_IDLE;
        endcase
    end

    // Datapath.
    always_comb begin
        n_step = r_step;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_mag  = r_mag;
        n_div  = r_div;
        n_amp  = r_amp;
        n_neg  = r_neg;
        case (r_state)
            obsr_pkg::DV_IDLE: begin
                if (i_start) begin
                    n_mag = i_req.mag;
                    n_div = i_req.divisor;
                    n_amp = i_req.amp;
                    n_neg = i_req.neg;
                end
            end
            obsr_pkg::DV_MUL: begin
                // The upper part is already below the divisor, since the
                // quotient fits in the amplitude width.
                n_rem  = w_prod[PRODW-1:obsr_pkg::AMP_W];
                n_quo  = w_prod[obsr_pkg::AMP_W-1:0];
                n_step = '0;
            end
            obsr_pkg::DV_STEP: begin
                n_rem  = w_fit ? w_trial[obsr_pkg::ACC_W-1:0]
                               : {r_rem[obsr_pkg::ACC_W-2:0], r_quo[obsr_pkg::AMP_W-1]};
                n_quo  = {r_quo[obsr_pkg::AMP_W-2:0], w_fit};
                n_step = r_step + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_done = (r_state == obsr_pkg::DV_DONE);
        o_quot = r_neg ? -w_q_ext : w_q_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= obsr_pkg::DV_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_mag <= n_mag;
        r_div <= n_div;
        r_amp <= n_amp;
        r_neg <= n_neg;
    end

endmodule

@@ rtl/obsr_checker.sv @@
// Port-level checks for the one-bit speaker PCM resampler, bound to the top level.
// Depends on obsr_pkg and one_bit_speaker_pcm_resampler.
module obsr_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input obsr_pkg::t_out_item             o_out_data
);

    logic w_out_xfer;
    assign w_out_xfer = o_out_valid && !i_out_stall;

    // A stalled result stays offered unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or was withdrawn");

    // No new tick is taken while a result is pending.
    a_busy_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while a result is pending");

    // After a non-final sample transfer the tick is still in progress.
    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && !o_out_data.last_sample) |=> (o_in_stall && !o_out_valid))
        else $error("tick ended or result repeated after a non-final sample");

    // The final sample of a tick is not followed at once by another.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && o_out_data.last_sample) |=> !o_out_valid)
        else $error("result offered right after the final sample");

endmodule

bind one_bit_speaker_pcm_resampler obsr_checker u_obsr_checker (.*);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for one_bit_speaker_pcm_resampler: a queue-fed tick driver,
// a sample monitor and a box-average predictor kept inside the bench.
// Depends on obsr_pkg and the resampler RTL.
module testbench;
    import obsr_pkg::*;

    localparam int LIMIT_CYCLES  = 5_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_PRINTS    = 40;
    localparam longint SAMPLE_MIN = -32768;
    localparam longint SAMPLE_MAX = 32767;
    localparam logic [ACC_W-1:0] ACC_TOP = {ACC_W{1'b1}};

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_data   = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_stall;
    logic                  out_valid;
    t_out_item             out_data;
    logic                  cfg_ready;

    // Bench copy of the registers and accumulators.
    logic              cap_en;
    logic [CLK_W-1:0]  cpu_clk;
    logic [RATE_W-1:0] out_rate;
    logic [AMP_W-1:0]  amp;
    logic [ACC_W-1:0]  high_sum;
    logic [ACC_W-1:0]  win_len;
    logic [ACC_W-1:0]  phase_acc;

    t_in_item  tick_queue[$];
    t_out_item pending_samples[$];

    int     ticks_accepted  = 0;
    int     samples_checked = 0;
    int     reg_writes      = 0;
    int     error_count     = 0;
    int     send_gap        = 0;
    int     stall_left      = 0;
    bit     bursts_on       = 1'b1;
    logic   level           = 1'b0;
    longint cycle_count     = 0;

    one_bit_speaker_pcm_resampler dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [ACC_W-1:0] clip_add(logic [ACC_W-1:0] a, logic [63:0] b);
        logic [63:0] s;
        s = 64'(a) + b;
        return (s > 64'(ACC_TOP)) ? ACC_TOP : s[ACC_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] box_average();
        longint centred;
        longint avg;
        avg = 0;
        if (win_len != '0) begin
            centred = 2 * longint'(high_sum) - longint'(win_len);
            avg = (centred * longint'(amp)) / longint'(win_len);
        end
        if (avg < SAMPLE_MIN) avg = SAMPLE_MIN;
        if (avg > SAMPLE_MAX) avg = SAMPLE_MAX;
        return avg[SAMPLE_W-1:0];
    endfunction

    task automatic predict_samples(t_in_item tick);
        int        n;
        t_out_item s;
        n = 0;
        if (!cap_en || tick.cycles == '0) return;
        if (tick.speaker_level) high_sum = clip_add(high_sum, 64'(tick.cycles));
        win_len   = clip_add(win_len, 64'(tick.cycles));
        phase_acc = clip_add(phase_acc, 64'(out_rate) * 64'(tick.cycles));
        while (n < MAX_RESULTS && phase_acc >= ACC_W'(cpu_clk)) begin
            phase_acc     = phase_acc - ACC_W'(cpu_clk);
            s.sample      = box_average();
            // The loop ends here when the cap is reached or the phase falls short.
            s.last_sample = (n == MAX_RESULTS - 1) || (phase_acc < ACC_W'(cpu_clk));
            pending_samples.insert(pending_samples.size(), s);
            high_sum = '0;
            win_len  = '0;
            n++;
        end
        // Whatever the sample cap leaves over is thrown away.
        if (n == MAX_RESULTS && phase_acc >= ACC_W'(cpu_clk)) phase_acc = '0;
    endtask

    task automatic report_error(string msg);
        if (error_count < MAX_PRINTS) $display("[%0t] MISMATCH: %s", $time, msg);
        error_count++;
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            CFG_CAPTURE_ENABLE: cap_en   = data[0];
            CFG_CPU_CLOCK_HZ:   cpu_clk  = data[CLK_W-1:0];
            CFG_OUTPUT_RATE_HZ: out_rate = data[RATE_W-1:0];
            CFG_AMPLITUDE:      amp      = data[AMP_W-1:0];
            default: ;
        endcase
    endtask

    // Waits at falling edges so the check never races the driver or monitor.
    task automatic settle();
        @(negedge clk);
        while (tick_queue.size() != 0 || in_valid || pending_samples.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic add_tick(logic [CYC_W-1:0] cyc, logic lvl);
        t_in_item t;
        t.cycles        = cyc;
        t.speaker_level = lvl;
        tick_queue.insert(tick_queue.size(), t);
    endtask

    // Register data may carry random bits above the field width.
    function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] v,
                                                       int width, bit junk);
        logic [CFG_DATA_W-1:0] upper;
        upper = $urandom() << width;
        return junk ? (upper | v) : v;
    endfunction

    task automatic run_setting(logic cap, logic [CLK_W-1:0] cpu, logic [RATE_W-1:0] rate,
                               logic [AMP_W-1:0] a, int n_ticks, bit junk);
        settle();
        write_reg(CFG_CAPTURE_ENABLE, with_junk(32'(cap), 1, junk));
        write_reg(CFG_CPU_CLOCK_HZ, cpu);
        write_reg(CFG_OUTPUT_RATE_HZ, with_junk(32'(rate), RATE_W, junk));
        write_reg(CFG_AMPLITUDE, with_junk(32'(a), AMP_W, junk));
        @(negedge clk);
        for (int i = 0; i < n_ticks; i++) begin
            // Level runs give full-high and full-low windows as well as mixed ones.
            if ($urandom_range(0, 3) == 0) level = ~level;
            add_tick(($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255)),
                     level);
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_valid && !in_stall) begin
                predict_samples(in_data);
                ticks_accepted++;
                if (bursts_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 16);
            end
            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (tick_queue.size() > 0) begin
                    in_data  <= tick_queue[0];
                    tick_queue.delete(0);
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : sample_monitor
        t_out_item want;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (pending_samples.size() == 0) begin
                    report_error($sformatf("unexpected sample %0d last=%0b",
                                           out_data.sample, out_data.last_sample));
                end else begin
                    want = pending_samples[0];
                    pending_samples.delete(0);
                    if (out_data.sample !== want.sample)
                        report_error($sformatf("sample %0d, expected %0d",
                                               out_data.sample, want.sample));
                    if (out_data.last_sample !== want.last_sample)
                        report_error($sformatf("last_sample %0b, expected %0b",
                                               out_data.last_sample, want.last_sample));
                    samples_checked++;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (bursts_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 15);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d samples still expected",
                     cycle_count, pending_samples.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        logic [CLK_W-1:0]  cpu_pick;
        logic [RATE_W-1:0] rate_pick;
        cap_en    = RST_CAPTURE;
        cpu_clk   = RST_CPU_CLOCK;
        out_rate  = RST_OUT_RATE;
        amp       = RST_AMPLITUDE;
        high_sum  = '0;
        win_len   = '0;
        phase_acc = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: zero-cycle ticks, full-high, full-low and mixed windows.
        add_tick(8'd0, 1'b1);
        add_tick(8'd0, 1'b0);
        add_tick(8'd255, 1'b1);
        add_tick(8'd255, 1'b1);
        add_tick(8'd255, 1'b0);
        add_tick(8'd255, 1'b0);
        add_tick(8'd1, 1'b1);
        add_tick(8'd1, 1'b0);
        add_tick(8'd170, 1'b1);
        add_tick(8'd85, 1'b0);
        add_tick(8'd128, 1'b1);
        add_tick(8'd127, 1'b0);
        settle();

        // Capture off: ticks leave the accumulators untouched.
        write_reg(CFG_CAPTURE_ENABLE, 32'd0);
        @(negedge clk);
        add_tick(8'd255, 1'b1);
        add_tick(8'd200, 1'b0);
        add_tick(8'd1, 1'b1);
        settle();
        write_reg(CFG_CAPTURE_ENABLE, 32'd1);

        // Zero threshold: every nonzero tick runs into the per-tick sample cap.
        write_reg(CFG_CPU_CLOCK_HZ, 32'd0);
        @(negedge clk);
        add_tick(8'd10, 1'b1);
        add_tick(8'd200, 1'b0);
        settle();

        // Zero rate: the window keeps growing without samples.
        write_reg(CFG_CPU_CLOCK_HZ, 32'd3500000);
        write_reg(CFG_OUTPUT_RATE_HZ, 32'd0);
        @(negedge clk);
        add_tick(8'd255, 1'b1);
        add_tick(8'd255, 1'b1);
        add_tick(8'd100, 1'b0);
        settle();
        write_reg(CFG_OUTPUT_RATE_HZ, 32'd48000);
        @(negedge clk);
        add_tick(8'd255, 1'b0);

        run_setting(1'b1, 32'd3500000, 18'd48000, 15'h7FFF, 50, 1'b0);
        run_setting(1'b1, 32'd1, 18'd1, 15'd0, 12, 1'b0);
        run_setting(1'b1, 32'hFFFF_FFFF, 18'h3FFFF, 15'($urandom_range(0, 32767)), 40, 1'b1);
        for (int p = 0; p < 4; p++) begin
            rate_pick = 18'($urandom_range(1, 262143));
            cpu_pick  = 32'(rate_pick) * 32'($urandom_range(2, 300));
            run_setting(1'b1, cpu_pick, rate_pick, 15'($urandom_range(0, 32767)), 50, 1'b1);
        end
        settle();
        bursts_on = 1'b0;
        run_setting(1'b1, 32'd3500000, 18'd48000, 15'd8192, 50, 1'b1);
        settle();

        $display("Run covered %0d accepted ticks and %0d checked samples", ticks_accepted,
                 samples_checked);
        $display("across %0d register writes, including zero threshold and zero rate.",
                 reg_writes);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
